>>> src/fsp_pkg.sv
package fsp_pkg;

   localparam int COUNT_WIDTH = 32;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_HEADER  = 8'h3e;

   typedef enum logic [2:0] {
      MODE_LINE_START,
      MODE_HDR_FIRST,
      MODE_HDR_NAME,
      MODE_HDR_SKIP,
      MODE_SEQ
   } fsp_mode_type;

   typedef enum logic [1:0] {
      KIND_NAME,
      KIND_BASE,
      KIND_DONE,
      KIND_ERROR
   } fsp_kind_type;

   typedef enum logic [1:0] {
      ERR_ILLEGAL,
      ERR_EMPTY_HDR,
      ERR_EMPTY_SEQ
   } fsp_err_type;

   typedef struct packed {
      fsp_kind_type kind;
      logic [7:0]   out_byte;
      logic [31:0]  record_id;
      logic [1:0]   error_code;
      logic [31:0]  line_number;
   } fsp_result_type;

   // ASCII a-z only
   function automatic logic [7:0] upcase(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h61 && b <= 8'h7a) begin
         r = b - 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_base(input logic [7:0] b);
      logic ok;
      case (b) inside
         "A", "C", "G", "T", "U", "R", "Y", "K", "M",
         "S", "W", "B", "D", "H", "N", "X", "-": ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> src/fsp_parse_core.sv
module fsp_parse_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_input,
   output logic                   res_valid,
   output fsp_pkg::fsp_result_type res
);
   import fsp_pkg::*;

   fsp_mode_type           mode_ff, mode_in;
   logic                   header_seen_ff, header_seen_in;
   logic                   bases_ff, bases_in;
   logic                   halted_ff, halted_in;
   logic [COUNT_WIDTH-1:0] rec_cnt_ff, rec_cnt_in;
   logic [COUNT_WIDTH-1:0] lines_ff, lines_in;

   logic                   live;
   logic [7:0]             byte_up;
   logic                   base_ok;
   logic                   is_nl;
   logic                   is_sp;
   logic                   is_gt;
   logic [COUNT_WIDTH-1:0] line_base;
   logic [COUNT_WIDTH-1:0] err_line;

   assign live    = in_accept && !halted_ff;
   assign byte_up = upcase(data_byte);
   assign base_ok = is_base(byte_up);
   assign is_nl   = (data_byte == CHAR_NEWLINE);
   assign is_sp   = (data_byte == CHAR_SPACE);
   assign is_gt   = (data_byte == CHAR_HEADER);

   // end of input inside a line counts that line first
   assign line_base = (end_of_input && mode_ff != MODE_LINE_START && mode_ff != MODE_HDR_FIRST)
                      ? lines_ff + 1'b1 : lines_ff;
   assign err_line  = line_base + 1'b1;

   // next state
   always_comb begin
      mode_in        = mode_ff;
      header_seen_in = header_seen_ff;
      bases_in       = bases_ff;
      halted_in      = halted_ff;
      rec_cnt_in     = rec_cnt_ff;
      lines_in       = lines_ff;
      if (live) begin
         if (end_of_input) begin
            halted_in = 1'b1;
            lines_in  = line_base;
            if (mode_ff != MODE_HDR_FIRST && bases_ff) begin
               rec_cnt_in = rec_cnt_ff + 1'b1;
            end
         end else begin
            case (mode_ff)
               MODE_LINE_START: begin
                  if (is_nl) begin
                     mode_in = MODE_LINE_START;
                  end else if (is_gt) begin
                     if (header_seen_ff && !bases_ff) begin
                        halted_in = 1'b1;
                     end else begin
                        if (header_seen_ff) begin
                           rec_cnt_in = rec_cnt_ff + 1'b1;
                           bases_in   = 1'b0;
                        end
                        header_seen_in = 1'b1;
                        mode_in        = MODE_HDR_FIRST;
                     end
                  end else if (base_ok) begin
                     bases_in = 1'b1;
                     mode_in  = MODE_SEQ;
                  end else begin
                     halted_in = 1'b1;
                  end
               end
               MODE_HDR_FIRST: begin
                  if (is_nl || is_sp) begin
                     halted_in = 1'b1;
                  end else begin
                     mode_in = MODE_HDR_NAME;
                  end
               end
               MODE_HDR_NAME: begin
                  if (is_nl) begin
                     lines_in = lines_ff + 1'b1;
                     mode_in  = MODE_LINE_START;
                  end else if (is_sp) begin
                     mode_in = MODE_HDR_SKIP;
                  end
               end
               MODE_HDR_SKIP: begin
                  if (is_nl) begin
                     lines_in = lines_ff + 1'b1;
                     mode_in  = MODE_LINE_START;
                  end
               end
               MODE_SEQ: begin
                  if (is_nl) begin
                     lines_in = lines_ff + 1'b1;
                     mode_in  = MODE_LINE_START;
                  end else if (base_ok) begin
                     bases_in = 1'b1;
                  end else begin
                     halted_in = 1'b1;
                  end
               end
               default: begin
                  mode_in = MODE_LINE_START;
               end
            endcase
         end
      end
   end

   // result
   always_comb begin
      res_valid       = 1'b0;
      res.kind        = KIND_NAME;
      res.out_byte    = '0;
      res.record_id   = 32'(rec_cnt_ff);
      res.error_code  = '0;
      res.line_number = '0;
      if (live) begin
         if (end_of_input) begin
            res_valid = 1'b1;
            if (mode_ff == MODE_HDR_FIRST) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_EMPTY_HDR;
            end else if (!bases_ff) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_EMPTY_SEQ;
            end else begin
               res.kind = KIND_DONE;
            end
         end else begin
            case (mode_ff)
               MODE_LINE_START: begin
                  if (is_nl) begin
                     res_valid = 1'b0;
                  end else if (is_gt) begin
                     if (header_seen_ff) begin
                        res_valid = 1'b1;
                        if (!bases_ff) begin
                           res.kind       = KIND_ERROR;
                           res.error_code = ERR_EMPTY_SEQ;
                        end else begin
                           res.kind = KIND_DONE;
                        end
                     end
                  end else begin
                     res_valid = 1'b1;
                     if (base_ok) begin
                        res.kind     = KIND_BASE;
                        res.out_byte = byte_up;
                     end else begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ILLEGAL;
                     end
                  end
               end
               MODE_HDR_FIRST: begin
                  res_valid = 1'b1;
                  if (is_nl || is_sp) begin
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_EMPTY_HDR;
                  end else begin
                     res.kind     = KIND_NAME;
                     res.out_byte = data_byte;
                  end
               end
               MODE_HDR_NAME: begin
                  if (!is_nl && !is_sp) begin
                     res_valid    = 1'b1;
                     res.kind     = KIND_NAME;
                     res.out_byte = data_byte;
                  end
               end
               MODE_SEQ: begin
                  if (!is_nl) begin
                     res_valid = 1'b1;
                     if (base_ok) begin
                        res.kind     = KIND_BASE;
                        res.out_byte = byte_up;
                     end else begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ILLEGAL;
                     end
                  end
               end
               default: begin
                  res_valid = 1'b0;
               end
            endcase
         end
         if (res.kind == KIND_ERROR) begin
            res.line_number = 32'(err_line);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_LINE_START;
         header_seen_ff <= 1'b0;
         bases_ff       <= 1'b0;
         halted_ff      <= 1'b0;
         rec_cnt_ff     <= '0;
         lines_ff       <= '0;
      end else begin
         mode_ff        <= mode_in;
         header_seen_ff <= header_seen_in;
         bases_ff       <= bases_in;
         halted_ff      <= halted_in;
         rec_cnt_ff     <= rec_cnt_in;
         lines_ff       <= lines_in;
      end
   end

endmodule

>>> src/fsp_out_buffer.sv
module fsp_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fsp_pkg::fsp_result_type push_data,
   output logic                   ready,
   output logic                   out_valid,
   output fsp_pkg::fsp_result_type out_data,
   input  logic                   out_ready
);
   import fsp_pkg::*;

   logic           main_valid_ff, main_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   fsp_result_type main_ff, main_in;
   fsp_result_type skid_ff, skid_in;
   logic           pop;

   assign ready     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> src/fasta_stream_parser.sv
// FASTA text parser: one text byte per transfer on req_, end of text flagged
// by req_tlast (its data byte is ignored). One byte is taken every cycle while
// the two-entry output buffer has room; each byte gives at most one result,
// registered in the output buffer. Results are name bytes, uppercased
// bases, record done and errors; record_id and line_number are the low 32 bits
// of wrapping counters. After an error or the end of text the block drops all
// further input until reset.
module fasta_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] out_byte, [39:8] record_id,
                                    // [41:40] error_code, [73:42] line_number
   output logic [1:0]  rsp_tuser    // [1:0] kind
);
   import fsp_pkg::*;

   logic           in_accept;
   logic           res_valid;
   fsp_result_type res;
   fsp_result_type out_res;

   assign in_accept = req_tvalid && req_tready;

   fsp_parse_core u_core (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .data_byte    (req_tdata),
      .end_of_input (req_tlast),
      .res_valid    (res_valid),
      .res          (res)
   );

   fsp_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .ready     (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tuser = out_res.kind;
   assign rsp_tdata = {6'd0, out_res.line_number, out_res.error_code,
                       out_res.record_id, out_res.out_byte};

endmodule

>>> sim/tb_fasta_stream_parser.sv
module tb_fasta_stream_parser;
   import fsp_pkg::*;

   localparam int DIR_ROWS    = 20;
   localparam int ITEM_TARGET = 1800;
   localparam int CALM_ITEMS  = 150;
   localparam int LIMIT       = 200000;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [8*17-1:0] BASE_SET = "ACGTURYKMSWBDHNX-";

   typedef struct {
      logic [7:0]     b;
      logic           last;
      bit             typed;
      bit             yields;
      fsp_result_type res;
   } text_item_type;

   typedef struct {
      logic [7:0]   b;
      bit           typed;
      bit           yields;
      fsp_kind_type kind;
      logic [7:0]   ob;
      logic [31:0]  rid;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;          // [7:0] out_byte, [39:8] record_id,
                                    // [41:40] error_code, [73:42] line_number
   logic [1:0]  rsp_tuser;          // [1:0] kind

   fasta_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // opening text: bases before the first header, blank lines, name extremes,
   // skipped header text, trailing space, '>' inside a name
   dir_row_type opening [DIR_ROWS] = '{
      '{"a",          1, 1, KIND_BASE, "A",   32'd0},
      '{"-",          1, 1, KIND_BASE, "-",   32'd0},
      '{CHAR_NEWLINE, 1, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_NEWLINE, 1, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_HEADER,  1, 0, KIND_NAME, 8'd0,  32'd0},
      '{8'hff,        1, 1, KIND_NAME, 8'hff, 32'd0},
      '{8'h00,        1, 1, KIND_NAME, 8'h00, 32'd0},
      '{CHAR_SPACE,   1, 0, KIND_NAME, 8'd0,  32'd0},
      '{"q",          1, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_NEWLINE, 1, 0, KIND_NAME, 8'd0,  32'd0},
      '{"x",          0, 0, KIND_NAME, 8'd0,  32'd0},
      '{"n",          0, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_NEWLINE, 0, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_HEADER,  1, 1, KIND_DONE, 8'd0,  32'd0},
      '{"k",          1, 1, KIND_NAME, "k",   32'd1},
      '{CHAR_HEADER,  0, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_SPACE,   0, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_NEWLINE, 0, 0, KIND_NAME, 8'd0,  32'd0},
      '{"T",          0, 0, KIND_NAME, 8'd0,  32'd0},
      '{CHAR_NEWLINE, 0, 0, KIND_NAME, 8'd0,  32'd0}
   };

   text_item_type  fasta_text[$];
   fsp_result_type pending_results[$];
   int             errors = 0;
   int             taken = 0;
   int             cycles = 0;
   int             send_pct = 0;
   int             sink_pct = 0;
   int             sink_hold = 0;

   // parser state as seen by the predictor
   fsp_mode_type fasta_mode = MODE_LINE_START;
   bit           in_record = 0;
   bit           bases_seen = 0;
   bit           stopped = 0;
   logic [31:0]  rec_count = '0;
   logic [31:0]  line_count = '0;

   function automatic bit legal_base(input logic [7:0] c);
      bit hit;
      hit = 0;
      for (int i = 0; i < 17; i++) begin
         if (BASE_SET[8*i +: 8] == c) begin
            hit = 1;
         end
      end
      return hit;
   endfunction

   task automatic fasta_next(input logic [7:0] c, input logic eoi,
                             output bit got, output fsp_result_type r);
      bit          bad;
      bit          take_base;
      fsp_err_type code;
      logic [7:0]  up;
      bad = 0;
      take_base = 0;
      code = ERR_ILLEGAL;
      got = 0;
      r = '0;
      r.record_id = rec_count;
      if (stopped) begin
         return;
      end
      if (eoi) begin
         if (fasta_mode == MODE_HDR_FIRST) begin
            bad = 1;
            code = ERR_EMPTY_HDR;
         end else begin
            if (fasta_mode != MODE_LINE_START) begin
               line_count++;
               fasta_mode = MODE_LINE_START;
            end
            if (!bases_seen) begin
               bad = 1;
               code = ERR_EMPTY_SEQ;
            end else begin
               got = 1;
               r.kind = KIND_DONE;
               rec_count++;
               stopped = 1;
            end
         end
      end else begin
         case (fasta_mode)
            MODE_LINE_START: begin
               if (c == CHAR_HEADER) begin
                  if (in_record && !bases_seen) begin
                     bad = 1;
                     code = ERR_EMPTY_SEQ;
                  end else begin
                     if (in_record) begin
                        got = 1;
                        r.kind = KIND_DONE;
                        rec_count++;
                        bases_seen = 0;
                     end
                     in_record = 1;
                     fasta_mode = MODE_HDR_FIRST;
                  end
               end else if (c != CHAR_NEWLINE) begin
                  take_base = 1;
               end
            end
            MODE_HDR_FIRST: begin
               if (c == CHAR_NEWLINE || c == CHAR_SPACE) begin
                  bad = 1;
                  code = ERR_EMPTY_HDR;
               end else begin
                  fasta_mode = MODE_HDR_NAME;
                  got = 1;
                  r.kind = KIND_NAME;
                  r.out_byte = c;
               end
            end
            MODE_HDR_NAME: begin
               if (c == CHAR_NEWLINE) begin
                  line_count++;
                  fasta_mode = MODE_LINE_START;
               end else if (c == CHAR_SPACE) begin
                  fasta_mode = MODE_HDR_SKIP;
               end else begin
                  got = 1;
                  r.kind = KIND_NAME;
                  r.out_byte = c;
               end
            end
            MODE_HDR_SKIP: begin
               if (c == CHAR_NEWLINE) begin
                  line_count++;
                  fasta_mode = MODE_LINE_START;
               end
            end
            default: begin
               if (c == CHAR_NEWLINE) begin
                  line_count++;
                  fasta_mode = MODE_LINE_START;
               end else begin
                  take_base = 1;
               end
            end
         endcase
      end
      if (take_base) begin
         up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
         if (legal_base(up)) begin
            bases_seen = 1;
            fasta_mode = MODE_SEQ;
            got = 1;
            r.kind = KIND_BASE;
            r.out_byte = up;
         end else begin
            bad = 1;
            code = ERR_ILLEGAL;
         end
      end
      if (bad) begin
         got = 1;
         r.kind = KIND_ERROR;
         r.out_byte = '0;
         r.error_code = code;
         r.line_number = line_count + 32'd1;
         stopped = 1;
      end
   endtask

   task automatic add_byte(input logic [7:0] c, input logic last);
      text_item_type it;
      it.b = c;
      it.last = last;
      it.typed = 0;
      it.yields = 0;
      it.res = '0;
      fasta_text.insert(fasta_text.size(), it);
   endtask

   task automatic add_name();
      logic [7:0] c;
      repeat ($urandom_range(1, 8)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_NEWLINE || c == CHAR_SPACE);
         add_byte(c, 1'b0);
      end
   endtask

   task automatic add_seq(input int len);
      logic [7:0] c;
      repeat (len) begin
         c = BASE_SET[8*$urandom_range(0, 16) +: 8];
         if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
            c = c + 8'd32;
         end
         add_byte(c, 1'b0);
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         errors++;
         $display("%0t %s: expected %0h, got %0h", $time, what, want, seen);
      end
   endtask

   always @(posedge clock) begin
      if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold = sink_hold - 1;
      end else if ($urandom_range(0, 99) < sink_pct) begin
         rsp_tready <= 1'b0;
         sink_hold = $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      bit             got;
      fsp_result_type r;
      text_item_type  it;
      if (!reset && req_tvalid && req_tready) begin
         it = fasta_text[taken];
         taken++;
         fasta_next(req_tdata, req_tlast, got, r);
         if (it.typed) begin
            got = it.yields;
            r = it.res;
         end
         if (got) begin
            pending_results.insert(pending_results.size(), r);
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, got kind %0d data %0h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            r = pending_results.pop_front();
            check_field("kind", 32'(r.kind), 32'(rsp_tuser));
            check_field("out_byte", 32'(r.out_byte), 32'(rsp_tdata[7:0]));
            check_field("record_id", r.record_id, rsp_tdata[39:8]);
            check_field("error_code", 32'(r.error_code), 32'(rsp_tdata[41:40]));
            check_field("line_number", r.line_number, rsp_tdata[73:42]);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      text_item_type it;
      logic [7:0]    c;
      int            n;
      int            pause_at;

      foreach (opening[k]) begin
         it.b = opening[k].b;
         it.last = 1'b0;
         it.typed = opening[k].typed;
         it.yields = opening[k].yields;
         it.res = '0;
         it.res.kind = opening[k].kind;
         it.res.out_byte = opening[k].ob;
         it.res.record_id = opening[k].rid;
         fasta_text.insert(fasta_text.size(), it);
      end

      // well-formed records with random names, header junk and blank lines
      while (fasta_text.size() < ITEM_TARGET) begin
         add_byte(CHAR_HEADER, 1'b0);
         add_name();
         case ($urandom_range(0, 3))
            1: add_byte(CHAR_SPACE, 1'b0);
            2: begin
               add_byte(CHAR_SPACE, 1'b0);
               repeat ($urandom_range(1, 10)) begin
                  do c = 8'($urandom_range(0, 255));
                  while (c == CHAR_NEWLINE);
                  add_byte(c, 1'b0);
               end
            end
            default: ;
         endcase
         add_byte(CHAR_NEWLINE, 1'b0);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) == 0) begin
               add_byte(CHAR_NEWLINE, 1'b0);
            end
            add_seq($urandom_range(1, 20));
            add_byte(CHAR_NEWLINE, 1'b0);
         end
      end

      // one way of ending the text; the block stops after it
      case ($urandom_range(0, 7))
         0: add_byte(8'($urandom_range(0, 255)), 1'b1);
         1: begin
            add_seq($urandom_range(1, 5));
            add_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         2: begin
            n = $urandom_range(0, 5);
            add_seq(n);
            case ($urandom_range(0, 3))
               0: c = 8'($urandom_range(128, 255));
               1: c = CHAR_CR;
               2: c = (n > 0) ? CHAR_HEADER : CHAR_CR;
               default: c = "e";
            endcase
            add_byte(c, 1'b0);
         end
         3: begin
            add_byte(CHAR_HEADER, 1'b0);
            add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE, 1'b0);
         end
         4: begin
            add_byte(CHAR_HEADER, 1'b0);
            add_byte(8'd0, 1'b1);
         end
         5: begin
            add_byte(CHAR_HEADER, 1'b0);
            add_name();
            add_byte(CHAR_NEWLINE, 1'b0);
            add_byte(CHAR_HEADER, 1'b0);
         end
         6: begin
            add_byte(CHAR_HEADER, 1'b0);
            add_name();
            if ($urandom_range(0, 1) == 1) begin
               add_byte(CHAR_NEWLINE, 1'b0);
            end
            add_byte(8'hff, 1'b1);
         end
         default: begin
            add_byte(CHAR_HEADER, 1'b0);
            add_name();
            add_byte(CHAR_NEWLINE, 1'b0);
            add_seq($urandom_range(1, 8));
            add_byte(CHAR_NEWLINE, 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
      repeat (12) begin
         add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      pause_at = DIR_ROWS + $urandom_range(200, 800);

      for (int i = 0; i < fasta_text.size(); i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: send_pct = 0;
               1: send_pct = 10;
               default: send_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: sink_pct = 0;
               1: sink_pct = 10;
               default: sink_pct = 40;
            endcase
         end
         if (i + CALM_ITEMS >= fasta_text.size()) begin
            send_pct = 0;
            sink_pct = 0;
         end
         if (i == DIR_ROWS || i == pause_at) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < send_pct) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= fasta_text[i].b;
         req_tlast  <= fasta_text[i].last;
         do @(posedge clock);
         while (!req_tready);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
